/* rtl/assert_macros.svh */
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain clocked property with reset disable
`define STK_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("stk checker: property violated");

// antecedent in one cycle, consequent in the next
`define STK_ASSERT_NEXT(name, clk, rst_n, pre, post) \
  `STK_ASSERT(name, clk, rst_n, (pre) |=> (post))

`endif

/* rtl/stk_pkg.sv */
// shared constants and types for the top-k tracker
package stk_pkg;

  localparam int unsigned MAX_KEEP = 16;
  localparam int unsigned ScoreW   = 32;
  localparam int unsigned IdW      = 16;
  localparam int unsigned RankW    = 4;
  localparam int unsigned KeepCfgW = 5;
  localparam int unsigned KeepW    = $clog2(MAX_KEEP + 1);
  localparam int unsigned KeepIdxW = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;
  localparam int unsigned InDataW  = ((ScoreW + IdW + 7) / 8) * 8;
  localparam int unsigned OutDataW = ((ScoreW + IdW + RankW + 7) / 8) * 8;
  localparam int unsigned RankLsb  = ScoreW + IdW;

  typedef struct packed {
    logic              valid;
    logic [ScoreW-1:0] score;
    logic [IdW-1:0]    id;
  } entry_t;

  typedef struct packed {
    logic              insert;
    logic              pop;
    logic              full;
    logic [ScoreW-1:0] score;
    logic [IdW-1:0]    id;
  } cell_ctl_t;

endpackage

/* rtl/stk_cell.sv */
// one slot of the sorted compare-and-shift row
module stk_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  stk_pkg::cell_ctl_t ctl_i,
  input  stk_pkg::entry_t   prev_i,
  input  logic              prev_ge_i,
  input  stk_pkg::entry_t   next_i,
  output stk_pkg::entry_t   entry_o,
  output logic              ge_o
);
  import stk_pkg::*;

  logic              valid_q, valid_d;
  logic [ScoreW-1:0] score_q, score_d;
  logic [IdW-1:0]    id_q, id_d;

  // equal scores stay ahead of the newcomer
  assign ge_o = valid_q && (score_q >= ctl_i.score);

  always_comb begin
    valid_d = valid_q;
    score_d = score_q;
    id_d    = id_q;
    if (ctl_i.pop) begin
      valid_d = next_i.valid;
      score_d = next_i.score;
      id_d    = next_i.id;
    end else if (ctl_i.insert && !ge_o) begin
      if (prev_ge_i) begin
        score_d = ctl_i.score;
        id_d    = ctl_i.id;
        valid_d = ctl_i.full ? valid_q : 1'b1;
      end else begin
        score_d = prev_i.score;
        id_d    = prev_i.id;
        // when full the tail entry drops off, occupancy unchanged
        valid_d = ctl_i.full ? valid_q : prev_i.valid;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    score_q <= score_d;
    id_q    <= id_d;
  end

  assign entry_o = '{valid: valid_q, score: score_q, id: id_q};

endmodule

/* rtl/streaming_top_k_tracker.sv */
// top-k tracker: row of sorted cells, report sequencer and output register
//
//  channel | dir | handshake                      | payload
//  s_axis  | in  | s_axis_tvalid / s_axis_tready  | tdata score,id  tuser rec valid  tlast eob
//  m_axis  | out | m_axis_tvalid / m_axis_tready  | tdata score,id,rank  tlast last of report
//  cfg     | in  | cfg_valid_i / cfg_ready_o      | cfg_data_i keep count
//
// records stream into the cell row at one per cycle while no report runs
// an end-of-batch transfer starts a report of the kept records, popped in rank order into the
// output register, then the sequencer returns to idle; s_axis_tready is low for the whole report
// a stall on m_axis holds the report, the row shifts only when the output register frees
// reset empties the row and sets keep count to MAX_KEEP
module streaming_top_k_tracker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [stk_pkg::InDataW-1:0]  s_axis_tdata,  // score, record_id
  input  logic                         s_axis_tuser,  // record_valid
  input  logic                         s_axis_tlast,  // end_of_batch
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [stk_pkg::OutDataW-1:0] m_axis_tdata,  // out_score, out_id, out_rank, zero pad
  output logic                         m_axis_tlast,  // out_last
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [stk_pkg::KeepCfgW-1:0] cfg_data_i
);
  import stk_pkg::*;

  localparam logic ST_IDLE   = 1'b0;
  localparam logic ST_REPORT = 1'b1;

  logic                state_q, state_d;
  logic [KeepCfgW-1:0] keep_q;
  logic [RankW-1:0]    rank_q, rank_d;

  logic              m_valid_q, m_valid_d;
  logic              m_last_q, m_last_d;
  logic [ScoreW-1:0] m_score_q, m_score_d;
  logic [IdW-1:0]    m_id_q, m_id_d;
  logic [RankW-1:0]  m_rank_q, m_rank_d;

  entry_t            entries   [MAX_KEEP];
  entry_t            next_ent  [MAX_KEEP];
  logic [MAX_KEEP-1:0] ge_vec;
  logic [MAX_KEEP-1:0] lt_vec;
  cell_ctl_t         ctl;

  logic              in_fire, out_free, full, any_lt;
  logic [KeepW-1:0]  keep_eff;
  logic [KeepIdxW-1:0] full_idx;

  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign out_free      = !m_valid_q || m_axis_tready;

  always_comb begin
    if (keep_q == '0) begin
      keep_eff = KeepW'(1);
    end else if (32'(keep_q) > MAX_KEEP) begin
      keep_eff = KeepW'(MAX_KEEP);
    end else begin
      keep_eff = KeepW'(keep_q);
    end
  end

  assign full_idx = KeepIdxW'(keep_eff - KeepW'(1));
  assign full     = entries[full_idx].valid;

  always_comb begin
    for (int i = 0; i < MAX_KEEP; i++) begin
      lt_vec[i] = entries[i].valid && !ge_vec[i];
    end
  end
  assign any_lt = |lt_vec;

  always_comb begin
    ctl.score  = s_axis_tdata[ScoreW-1:0];
    ctl.id     = s_axis_tdata[ScoreW +: IdW];
    ctl.full   = full;
    ctl.insert = in_fire && s_axis_tuser && (!full || any_lt);
    ctl.pop    = (state_q == ST_REPORT) && out_free && entries[0].valid;
  end

  for (genvar i = 0; i < MAX_KEEP; i++) begin : g_cell
    entry_t prev_ent;
    logic   prev_ge;
    if (i == 0) begin : g_head
      assign prev_ent = '0;
      assign prev_ge  = 1'b1;
    end else begin : g_body
      assign prev_ent = entries[i-1];
      assign prev_ge  = ge_vec[i-1];
    end
    if (i == MAX_KEEP - 1) begin : g_tail
      assign next_ent[i] = '0;
    end else begin : g_link
      assign next_ent[i] = entries[i+1];
    end

    stk_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctl_i     (ctl),
      .prev_i    (prev_ent),
      .prev_ge_i (prev_ge),
      .next_i    (next_ent[i]),
      .entry_o   (entries[i]),
      .ge_o      (ge_vec[i])
    );
  end

  always_comb begin
    state_d = state_q;
    rank_d  = rank_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire && s_axis_tlast) begin
          state_d = ST_REPORT;
        end
      end
      ST_REPORT: begin
        if (!entries[0].valid) begin
          state_d = ST_IDLE;
          rank_d  = '0;
        end else if (ctl.pop) begin
          rank_d = rank_q + RankW'(1);
        end
      end
      default: begin
        state_d = ST_IDLE;
        rank_d  = '0;
      end
    endcase
  end

  always_comb begin
    m_valid_d = m_valid_q;
    m_last_d  = m_last_q;
    m_score_d = m_score_q;
    m_id_d    = m_id_q;
    m_rank_d  = m_rank_q;
    if (ctl.pop) begin
      m_valid_d = 1'b1;
      m_score_d = entries[0].score;
      m_id_d    = entries[0].id;
      m_rank_d  = rank_q;
      m_last_d  = !next_ent[0].valid;
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      rank_q    <= '0;
      keep_q    <= KeepCfgW'(MAX_KEEP);
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      rank_q    <= rank_d;
      m_valid_q <= m_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        keep_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    m_last_q  <= m_last_d;
    m_score_q <= m_score_d;
    m_id_q    <= m_id_d;
    m_rank_q  <= m_rank_d;
  end

  always_comb begin
    m_axis_tdata                   = '0;
    m_axis_tdata[ScoreW-1:0]       = m_score_q;
    m_axis_tdata[ScoreW +: IdW]    = m_id_q;
    m_axis_tdata[RankLsb +: RankW] = m_rank_q;
  end
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tlast  = m_last_q;

endmodule

/* rtl/stk_checker.sv */
// port-level checker for the top-k tracker, bound to the top level
`include "assert_macros.svh"

module stk_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         s_axis_tvalid,
  input logic                         s_axis_tready,
  input logic                         s_axis_tlast,
  input logic                         m_axis_tvalid,
  input logic                         m_axis_tready,
  input logic [stk_pkg::OutDataW-1:0] m_axis_tdata,
  input logic                         m_axis_tlast
);
  import stk_pkg::*;

  logic                in_xfer, out_xfer, out_stall, out_more;
  logic [RankW-1:0]    out_rank;
  logic [OutDataW+1:0] out_word;

  assign in_xfer   = s_axis_tvalid && s_axis_tready;
  assign out_xfer  = m_axis_tvalid && m_axis_tready;
  assign out_stall = m_axis_tvalid && !m_axis_tready;
  assign out_more  = out_xfer && !m_axis_tlast;
  assign out_rank  = m_axis_tdata[RankLsb +: RankW];
  assign out_word  = {m_axis_tvalid, m_axis_tlast, m_axis_tdata};

  // stalled output transfer keeps its payload
  `STK_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_stall, $stable(out_word))
  // an end-of-batch transfer blocks the input while the report runs
  `STK_ASSERT_NEXT(a_eob_blocks, clk_i, rst_ni, in_xfer && s_axis_tlast, !s_axis_tready)
  // a report record that is not the last is followed at once by the next one
  `STK_ASSERT_NEXT(a_report_gapless, clk_i, rst_ni, out_more, m_axis_tvalid)
  // ranks within one report count up by one
  `STK_ASSERT_NEXT(a_rank_step, clk_i, rst_ni, out_more, out_rank == $past(out_rank) + RankW'(1))

endmodule

bind streaming_top_k_tracker stk_checker u_stk_checker (.*);
